### hdl/tgq_pkg.sv
package tgq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TICKET_W    = 16;
    localparam int SIZE_W      = 8;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;

    localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SERVE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [TICKET_W-1:0] FIRST_TICKET = 16'd1;

    typedef struct packed {
        logic compare;
        logic load;
        logic shift;
        logic trim;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

endpackage

### hdl/tgq_cell.sv
module tgq_cell (
    input  logic                             clk,
    input  tgq_pkg::cell_ctl_t               ctl,
    input  logic [tgq_pkg::TICKET_W-1:0]     key,
    input  logic [tgq_pkg::TICKET_W-1:0]     new_ticket,
    input  logic [tgq_pkg::SIZE_W-1:0]       new_size,
    input  logic [tgq_pkg::SIZE_W-1:0]       trim_amount,
    input  logic [tgq_pkg::TICKET_W-1:0]     nbr_ticket,
    input  logic [tgq_pkg::SIZE_W-1:0]       nbr_size,
    output logic [tgq_pkg::TICKET_W-1:0]     ticket,
    output logic [tgq_pkg::SIZE_W-1:0]       size,
    output logic                             match
);
    import tgq_pkg::*;

    logic [TICKET_W-1:0] ticket_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic                match_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ticket_reg <= new_ticket;
            size_reg   <= new_size;
        end
        else if (ctl.shift)
        begin
            ticket_reg <= nbr_ticket;
            size_reg   <= nbr_size;
        end
        else if (ctl.trim)
        begin
            size_reg <= size_reg - trim_amount;
        end
        if (ctl.compare)
        begin
            match_reg <= (ticket_reg == key);
        end
    end

    assign ticket = ticket_reg;
    assign size   = size_reg;
    assign match  = match_reg;

endmodule

### hdl/ticketed_group_queue.sv
// channel | direction | handshake            | beat fields
// in      | input     | in_valid / in_ready  | req_type, group_size, serve_limit, cancel_ticket
// out     | output    | out_valid / out_ready| ticket_out, served_count, status
//
// A request is taken in an idle cycle, then passes through the cell row in
// EVAL, which compares every cell's ticket with the key and latches the tail
// ticket, and then in EXEC, which loads, trims or shifts. One request is in
// flight at a time.
// A finished result sits in the output register; a stalled out channel holds
// the row in its update cycle but not the input handshake of that request.
// Reset empties the queue at once; no clearing pass.
module ticketed_group_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tgq_pkg::REQ_W-1:0]        req_type,
    input  logic [tgq_pkg::SIZE_W-1:0]       group_size,
    input  logic [tgq_pkg::SIZE_W-1:0]       serve_limit,
    input  logic [tgq_pkg::TICKET_W-1:0]     cancel_ticket,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tgq_pkg::TICKET_W-1:0]     ticket_out,
    output logic [tgq_pkg::SIZE_W-1:0]       served_count,
    output logic [tgq_pkg::STATUS_W-1:0]     status
);
    import tgq_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [REQ_W-1:0]      req_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [SIZE_W-1:0]     limit_reg;
    logic [TICKET_W-1:0]   key_reg;
    logic [TICKET_W-1:0]   tail_reg, tail_next;
    logic [TICKET_W-1:0]   ticket_out_reg, ticket_out_next;
    logic [SIZE_W-1:0]     served_reg, served_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic [TICKET_W-1:0]   cell_ticket [QUEUE_DEPTH];
    logic [SIZE_W-1:0]     cell_size   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_match;
    logic [QUEUE_DEPTH-1:0] found_upto;
    cell_ctl_t             cell_ctl    [QUEUE_DEPTH];

    logic                  accept;
    logic                  exec_go;
    logic                  is_empty;
    logic                  is_full;
    logic                  head_bigger;
    logic                  found;
    logic [TICKET_W-1:0]   enq_ticket;
    logic                  do_load;
    logic                  do_trim;
    logic                  do_pop;
    logic                  do_cancel;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    assign is_empty    = (count_reg == '0);
    assign is_full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_bigger = (cell_size[0] > limit_reg);
    assign found       = found_upto[QUEUE_DEPTH-1];
    assign enq_ticket  = is_empty ? FIRST_TICKET : tail_reg + FIRST_TICKET;

    assign do_load   = exec_go && (req_reg == REQ_ENQUEUE) && !is_full;
    assign do_trim   = exec_go && (req_reg == REQ_SERVE) && !is_empty && head_bigger;
    assign do_pop    = exec_go && (req_reg == REQ_SERVE) && !is_empty && !head_bigger;
    assign do_cancel = exec_go && (req_reg == REQ_CANCEL) && found;

    // first live match, nearest the head, and everything behind it
    always_comb
    begin
        logic run;
        run = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            run = run | (cell_match[i] && (CNT_W'(i) < count_reg));
            found_upto[i] = run;
        end
    end

    always_comb
    begin
        tail_next = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (CNT_W'(i + 1) == count_reg)
            begin
                tail_next = tail_next | cell_ticket[i];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic [TICKET_W-1:0] nbr_ticket;
            logic [SIZE_W-1:0]   nbr_size;

            if (g == QUEUE_DEPTH - 1)
            begin : g_last
                assign nbr_ticket = cell_ticket[g];
                assign nbr_size   = cell_size[g];
            end
            else
            begin : g_mid
                assign nbr_ticket = cell_ticket[g+1];
                assign nbr_size   = cell_size[g+1];
            end

            assign cell_ctl[g].compare = (state_reg == ST_EVAL);
            assign cell_ctl[g].load    = do_load && (CNT_W'(g) == count_reg);
            assign cell_ctl[g].shift   = do_pop || (do_cancel && found_upto[g]);
            assign cell_ctl[g].trim    = do_trim && (g == 0);

            tgq_cell u_cell (
                .clk         (clk),
                .ctl         (cell_ctl[g]),
                .key         (key_reg),
                .new_ticket  (enq_ticket),
                .new_size    (size_reg),
                .trim_amount (limit_reg),
                .nbr_ticket  (nbr_ticket),
                .nbr_size    (nbr_size),
                .ticket      (cell_ticket[g]),
                .size        (cell_size[g]),
                .match       (cell_match[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_load)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop || do_cancel)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        ticket_out_next = '0;
        served_next     = '0;
        status_next     = STATUS_OK;
        case (req_reg)
            REQ_ENQUEUE:
            begin
                if (is_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    ticket_out_next = enq_ticket;
                end
            end
            REQ_SERVE:
            begin
                if (!is_empty)
                begin
                    served_next = head_bigger ? limit_reg : cell_size[0];
                end
            end
            REQ_CANCEL:
            begin
                if (!found)
                begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            size_reg  <= group_size;
            limit_reg <= serve_limit;
            key_reg   <= cancel_ticket;
        end
        if (state_reg == ST_EVAL)
        begin
            tail_reg <= tail_next;
        end
        if (exec_go)
        begin
            ticket_out_reg <= ticket_out_next;
            served_reg     <= served_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ticket_out   = ticket_out_reg;
    assign served_count = served_reg;
    assign status       = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above depth");

    a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_go |=> $stable(count_reg))
        else $error("occupancy moved outside update cycle");

    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EVAL))
        else $error("accepted request did not start compare");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result appeared without update cycle");

    a_single_row_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({do_load, do_trim, do_pop, do_cancel}))
        else $error("more than one row operation");

endmodule
